>>> hw/rtl/lpr_pkg.sv
// lpr_pkg: shared types and constants for the longest prefix route lookup block
// no dependencies

package lpr_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned PORT_W = 2;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [PORT_W-1:0] port;
  } route_t;

  typedef struct packed {
    route_t route;
    logic   vld;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] port;
  } best_t;

endpackage

>>> hw/rtl/lpr_table.sv
// lpr_table: route table memory with one write and one registered read port
// valid bits live in flops cleared at reset; depends on lpr_pkg

module lpr_table #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IW      = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  lpr_pkg::entry_t wr_data,
  input  logic [IW-1:0]   rd_addr,
  output lpr_pkg::entry_t rd_data
);

  lpr_pkg::route_t mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  lpr_pkg::route_t    rd_route;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data.route;
    end
    rd_route <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= wr_data.vld;
      end
      rd_vld <= valid[rd_addr];
    end
  end

  assign rd_data = '{route: rd_route, vld: rd_vld};

endmodule

>>> hw/rtl/lpr_match.sv
// lpr_match: shared masked compare unit that keeps the best match so far
// one table entry per cycle while en is high; depends on lpr_pkg

module lpr_match #(
  parameter int unsigned IW = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        en,
  input  logic [lpr_pkg::ADDR_W-1:0]  address,
  input  lpr_pkg::entry_t             entry,
  input  logic [IW-1:0]               slot,
  output lpr_pkg::best_t              best,
  output logic [IW-1:0]               best_slot
);

  logic [lpr_pkg::ADDR_W-1:0] best_mask;
  logic                       is_match;
  logic                       better;

  assign is_match = entry.vld &&
                    (((address ^ entry.route.prefix) & entry.route.mask) == '0);
  assign better   = !best.hit || (entry.route.mask > best_mask);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      best.hit  <= 1'b0;
      best.port <= '0;
      best_mask <= '0;
      best_slot <= '0;
    end else if (en && is_match && better) begin
      best.hit  <= 1'b1;
      best.port <= entry.route.port;
      best_mask <= entry.route.mask;
      best_slot <= slot;
    end
  end

endmodule

>>> hw/rtl/longest_prefix_route_lookup.sv
// longest_prefix_route_lookup: write item stores one slot
// lookup walks the table through one shared masked compare, one entry per cycle,
// then holds its result until taken; a new request is accepted only back in idle
// busy while a lookup is in flight or its result waits
// reset clears every valid bit at once and returns the sequencer to idle
// depends on lpr_pkg, lpr_table, lpr_match

module longest_prefix_route_lookup #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned PORTS   = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              kind,
  input  logic [lpr_pkg::SLOT_W-1:0]        entry_slot,
  input  logic [lpr_pkg::ADDR_W-1:0]        entry_prefix,
  input  logic [lpr_pkg::ADDR_W-1:0]        entry_mask,
  input  logic [lpr_pkg::PORT_W-1:0]        entry_port,
  input  logic                              entry_valid,
  input  logic [lpr_pkg::ADDR_W-1:0]        lookup_address,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic                              found,
  output logic [lpr_pkg::PORT_W-1:0]        out_port,
  output logic [lpr_pkg::SLOT_W-1:0]        out_slot
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] CNT_END = CW'(ENTRIES);
  localparam logic [31:0] PORT_SAT_FULL = 32'(PORTS - 1);

  lpr_pkg::state_t state, state_next;

  logic [CW-1:0]              cnt, cnt_next;
  logic                       rd_pend, rd_pend_next;
  logic [IW-1:0]              rd_slot;
  logic [lpr_pkg::ADDR_W-1:0] address;

  logic                       req_take;
  logic                       lookup_take;
  logic                       issue;
  logic                       wr_en;
  lpr_pkg::entry_t            wr_data;
  lpr_pkg::entry_t            rd_data;
  lpr_pkg::best_t             best;
  logic [IW-1:0]              best_slot;

  assign req_take    = req_valid && !req_stall;
  assign lookup_take = req_take && (kind == lpr_pkg::KIND_LOOKUP);
  assign wr_en       = req_take && (kind == lpr_pkg::KIND_WRITE) &&
                       ({28'd0, entry_slot} < 32'(ENTRIES));

  always_comb begin
    wr_data.route.prefix = entry_prefix;
    wr_data.route.mask   = entry_mask;
    wr_data.vld          = entry_valid;
    if ({30'd0, entry_port} >= 32'(PORTS)) begin
      wr_data.route.port = PORT_SAT_FULL[lpr_pkg::PORT_W-1:0];
    end else begin
      wr_data.route.port = entry_port;
    end
  end

  lpr_table #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (IW'(entry_slot)),
    .wr_data (wr_data),
    .rd_addr (cnt[IW-1:0]),
    .rd_data (rd_data)
  );

  lpr_match #(
    .IW (IW)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .start     (lookup_take),
    .en        (rd_pend),
    .address   (address),
    .entry     (rd_data),
    .slot      (rd_slot),
    .best      (best),
    .best_slot (best_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lpr_pkg::ST_IDLE;
      cnt     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      rd_pend <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= cnt[IW-1:0];
    if (lookup_take) begin
      address <= lookup_address;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    rd_pend_next = 1'b0;
    issue        = 1'b0;
    req_stall    = 1'b1;
    rsp_valid    = 1'b0;
    case (state)
      lpr_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (lookup_take) begin
          state_next = lpr_pkg::ST_SCAN;
          cnt_next   = '0;
        end
      end
      lpr_pkg::ST_SCAN: begin
        if (cnt != CNT_END) begin
          issue        = 1'b1;
          rd_pend_next = 1'b1;
          cnt_next     = cnt + CW'(1);
        end else if (!rd_pend) begin
          state_next = lpr_pkg::ST_RESULT;
        end
      end
      lpr_pkg::ST_RESULT: begin
        rsp_valid = 1'b1;
        if (!rsp_stall) begin
          state_next = lpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  assign found    = best.hit;
  assign out_port = best.port;
  assign out_slot = lpr_pkg::SLOT_W'(best_slot);

  // each table read issued during the scan is compared in the next cycle
  a_pend_after_issue: assert property (@(posedge clk) disable iff (rst)
    issue |=> rd_pend)
    else $error("table read issued without a pending compare");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !found) |-> (out_port == '0 && out_slot == '0))
    else $error("miss result carries nonzero port or slot");

  a_lookup_scans: assert property (@(posedge clk) disable iff (rst)
    lookup_take |=> (state == lpr_pkg::ST_SCAN && cnt == '0))
    else $error("lookup transaction did not start a table scan");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid || rd_pend) |-> !req_take)
    else $error("request taken while a lookup is in flight");

endmodule
